### sv/bpca_pkg.sv
package bpca_pkg;

	localparam int MAX_CLUSTERS   = 16;
	localparam int PALETTE_SLOTS  = 128;
	localparam int MAX_TRI_JOINTS = 12;
	localparam int JOINT_ID_BITS  = 8;

	localparam int CL_W    = $clog2(MAX_CLUSTERS);
	localparam int TOT_W   = $clog2(MAX_CLUSTERS + 1);
	localparam int SLOT_W  = $clog2(PALETTE_SLOTS);
	localparam int FILL_W  = $clog2(PALETTE_SLOTS + 1);
	localparam int PIDX_W  = $clog2(MAX_TRI_JOINTS);
	localparam int PCNT_W  = $clog2(MAX_TRI_JOINTS + 1);
	localparam int ADDR_W  = CL_W + SLOT_W;
	localparam int ROOM_W  = FILL_W + 2;
	localparam int STORE_DEPTH = MAX_CLUSTERS * PALETTE_SLOTS;

	localparam logic [7:0] SLOT_LIMIT_RESET = 8'd78;

	localparam logic REQ_JOINT = 1'b0;
	localparam logic REQ_CLEAR = 1'b1;

	localparam logic [1:0] PLACE_CONTAINED = 2'd0;
	localparam logic [1:0] PLACE_OVERLAP   = 2'd1;
	localparam logic [1:0] PLACE_FREE      = 2'd2;
	localparam logic [1:0] PLACE_NEW       = 2'd3;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_OVER = 2'd2;

	localparam logic REG_SLOT_LIMIT = 1'b0;

	typedef struct packed {
		logic take;
		logic rd;
		logic eval;
		logic decide;
		logic ins;
		logic load;
	} bpca_cmd_t;

	typedef struct packed {
		logic rd_more;
		logic rd_busy;
		logic cl_last;
		logic skip_scan;
		logic ins_needed;
		logic ins_last;
	} bpca_stat_t;

endpackage

### sv/bpca_ram.sv
module bpca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### sv/bpca_ctrl.sv
module bpca_ctrl import bpca_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic       item_places,
	output logic       m_tvalid,
	input  logic       m_tready,
	input  bpca_stat_t stat,
	output bpca_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_READ,
		ST_EVAL,
		ST_DECIDE,
		ST_INSERT,
		ST_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   m_tvalid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				cmd.take = s_tvalid;
				if (s_tvalid && item_places) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				state_d = stat.skip_scan ? ST_DECIDE : ST_READ;
			end
			ST_READ: begin
				cmd.rd = stat.rd_more;
				if (!stat.rd_more && !stat.rd_busy) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = stat.cl_last ? ST_DECIDE : ST_READ;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = stat.ins_needed ? ST_INSERT : ST_DONE;
			end
			ST_INSERT: begin
				cmd.ins = 1'b1;
				if (stat.ins_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

### sv/bpca_dp.sv
module bpca_dp import bpca_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  bpca_cmd_t                cmd,
	output bpca_stat_t               stat,
	input  logic                     req_type,
	input  logic                     joint_valid,
	input  logic [JOINT_ID_BITS-1:0] jnt_id,
	input  logic [7:0]               slot_limit,
	output logic [CL_W-1:0]          cluster_index,
	output logic [1:0]               placement,
	output logic [FILL_W-1:0]        cluster_fill,
	output logic [1:0]               status
);

	// Pending joint list of the current triangle.
	logic [JOINT_ID_BITS-1:0] pend_q [MAX_TRI_JOINTS];
	logic [PCNT_W-1:0]        pcnt_q;
	logic                     over_q;

	// Cluster table bookkeeping.
	logic [FILL_W-1:0] fill_q [MAX_CLUSTERS];
	logic [TOT_W-1:0]  total_q;

	// Scan position and per-cluster hit mask.
	logic [CL_W-1:0]           c_q;
	logic [FILL_W-1:0]         j_q;
	logic [MAX_TRI_JOINTS-1:0] mask_q;
	logic                      rv_s1;

	// Best candidates found so far.
	logic                      cont_found_q;
	logic [CL_W-1:0]           cont_idx_q;
	logic                      ov_found_q;
	logic signed [ROOM_W-1:0]  ov_best_q;
	logic [CL_W-1:0]           ov_idx_q;
	logic [MAX_TRI_JOINTS-1:0] ov_mask_q;
	logic                      ff_found_q;
	logic signed [ROOM_W-1:0]  ff_best_q;
	logic [CL_W-1:0]           ff_idx_q;
	logic [MAX_TRI_JOINTS-1:0] ff_mask_q;

	// Chosen cluster and insertion walk.
	logic [CL_W-1:0]           sel_q;
	logic [MAX_TRI_JOINTS-1:0] sel_mask_q;
	logic [PCNT_W-1:0]         k_q;
	logic [1:0]                place_q;
	logic [1:0]                stat_q;

	logic [CL_W-1:0]   out_idx_q;
	logic [1:0]        out_place_q;
	logic [FILL_W-1:0] out_fill_q;
	logic [1:0]        out_stat_q;

	logic [JOINT_ID_BITS-1:0]  rdata;
	logic                      ram_we;
	logic [ADDR_W-1:0]         waddr;
	logic [ADDR_W-1:0]         raddr;

	logic                      seen;
	logic [MAX_TRI_JOINTS-1:0] vmask;
	logic [MAX_TRI_JOINTS-1:0] missing;
	logic [PCNT_W-1:0]         need;
	logic signed [ROOM_W-1:0]  lim;
	logic signed [ROOM_W-1:0]  room;
	logic signed [ROOM_W-1:0]  need_s;
	logic signed [ROOM_W-1:0]  tgt_s;
	logic                      opens_new;
	logic                      full_table;

	always_comb begin
		seen    = 1'b0;
		vmask   = '0;
		need    = '0;
		for (int k = 0; k < MAX_TRI_JOINTS; k++) begin
			vmask[k] = (PCNT_W'(k) < pcnt_q);
			if (vmask[k] && pend_q[k] == jnt_id) begin
				seen = 1'b1;
			end
		end
		missing = vmask & ~mask_q;
		for (int k = 0; k < MAX_TRI_JOINTS; k++) begin
			need = need + PCNT_W'(missing[k]);
		end
	end

	assign lim    = ({2'b00, slot_limit} > ROOM_W'(PALETTE_SLOTS)) ?
			ROOM_W'(PALETTE_SLOTS) : ROOM_W'(slot_limit);
	assign room   = lim - signed'({2'b00, fill_q[c_q]});
	assign need_s = signed'(ROOM_W'(need));
	assign tgt_s  = signed'(ROOM_W'(pcnt_q));

	assign full_table = (total_q >= TOT_W'(MAX_CLUSTERS));
	assign opens_new  = !cont_found_q && !ov_found_q && !ff_found_q;

	assign stat.rd_more    = (j_q < fill_q[c_q]);
	assign stat.rd_busy    = rv_s1;
	assign stat.cl_last    = ({1'b0, c_q} == total_q - TOT_W'(1));
	assign stat.skip_scan  = over_q || (total_q == '0);
	assign stat.ins_needed = !over_q && !cont_found_q && (pcnt_q != '0) &&
			!(opens_new && full_table);
	assign stat.ins_last   = (k_q == pcnt_q - PCNT_W'(1));

	assign raddr  = {c_q, j_q[SLOT_W-1:0]};
	assign waddr  = {sel_q, fill_q[sel_q][SLOT_W-1:0]};
	assign ram_we = cmd.ins && (k_q < pcnt_q) && !sel_mask_q[k_q[PIDX_W-1:0]] &&
			(fill_q[sel_q] < FILL_W'(PALETTE_SLOTS));

	bpca_ram #(
		.WIDTH(JOINT_ID_BITS),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(pend_q[k_q[PIDX_W-1:0]]),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.take && req_type == REQ_JOINT && joint_valid && !seen &&
				pcnt_q < PCNT_W'(MAX_TRI_JOINTS)) begin
			pend_q[pcnt_q[PIDX_W-1:0]] <= jnt_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q       <= '0;
			over_q       <= 1'b0;
			for (int c = 0; c < MAX_CLUSTERS; c++) begin
				fill_q[c] <= '0;
			end
			total_q      <= '0;
			c_q          <= '0;
			j_q          <= '0;
			mask_q       <= '0;
			rv_s1        <= 1'b0;
			cont_found_q <= 1'b0;
			cont_idx_q   <= '0;
			ov_found_q   <= 1'b0;
			ov_best_q    <= '0;
			ov_idx_q     <= '0;
			ov_mask_q    <= '0;
			ff_found_q   <= 1'b0;
			ff_best_q    <= '0;
			ff_idx_q     <= '0;
			ff_mask_q    <= '0;
			sel_q        <= '0;
			sel_mask_q   <= '0;
			k_q          <= '0;
			place_q      <= PLACE_CONTAINED;
			stat_q       <= STAT_OK;
			out_idx_q    <= '0;
			out_place_q  <= PLACE_CONTAINED;
			out_fill_q   <= '0;
			out_stat_q   <= STAT_OK;
		end else begin
			rv_s1 <= cmd.rd;
			if (rv_s1) begin
				for (int k = 0; k < MAX_TRI_JOINTS; k++) begin
					if (vmask[k] && pend_q[k] == rdata) begin
						mask_q[k] <= 1'b1;
					end
				end
			end

			if (cmd.take) begin
				c_q          <= '0;
				j_q          <= '0;
				mask_q       <= '0;
				cont_found_q <= 1'b0;
				ov_found_q   <= 1'b0;
				ov_best_q    <= lim;
				ff_found_q   <= 1'b0;
				ff_best_q    <= lim;
				k_q          <= '0;
				if (req_type == REQ_CLEAR) begin
					for (int c = 0; c < MAX_CLUSTERS; c++) begin
						fill_q[c] <= '0;
					end
					total_q <= '0;
					pcnt_q  <= '0;
					over_q  <= 1'b0;
				end else if (joint_valid && !seen) begin
					if (pcnt_q < PCNT_W'(MAX_TRI_JOINTS)) begin
						pcnt_q <= pcnt_q + PCNT_W'(1);
					end else begin
						over_q <= 1'b1;
					end
				end
			end

			if (cmd.rd) begin
				j_q <= j_q + FILL_W'(1);
			end

			if (cmd.eval) begin
				if (missing == '0 && !cont_found_q) begin
					cont_found_q <= 1'b1;
					cont_idx_q   <= c_q;
				end
				if (room > need_s && need_s < ov_best_q) begin
					ov_found_q <= 1'b1;
					ov_best_q  <= need_s;
					ov_idx_q   <= c_q;
					ov_mask_q  <= mask_q;
				end
				if (room > tgt_s && room < ff_best_q) begin
					ff_found_q <= 1'b1;
					ff_best_q  <= room;
					ff_idx_q   <= c_q;
					ff_mask_q  <= mask_q;
				end
				c_q    <= c_q + CL_W'(1);
				j_q    <= '0;
				mask_q <= '0;
			end

			if (cmd.decide) begin
				if (over_q) begin
					sel_q   <= '0;
					place_q <= PLACE_CONTAINED;
					stat_q  <= STAT_OVER;
				end else if (cont_found_q) begin
					sel_q   <= cont_idx_q;
					place_q <= PLACE_CONTAINED;
					stat_q  <= STAT_OK;
				end else if (ov_found_q) begin
					sel_q      <= ov_idx_q;
					sel_mask_q <= ov_mask_q;
					place_q    <= PLACE_OVERLAP;
					stat_q     <= STAT_OK;
				end else if (ff_found_q) begin
					sel_q      <= ff_idx_q;
					sel_mask_q <= ff_mask_q;
					place_q    <= PLACE_FREE;
					stat_q     <= STAT_OK;
				end else if (full_table) begin
					sel_q   <= '0;
					place_q <= PLACE_NEW;
					stat_q  <= STAT_FULL;
				end else begin
					sel_q                    <= total_q[CL_W-1:0];
					sel_mask_q               <= '0;
					place_q                  <= PLACE_NEW;
					stat_q                   <= STAT_OK;
					fill_q[total_q[CL_W-1:0]] <= '0;
					total_q                  <= total_q + TOT_W'(1);
				end
			end

			if (cmd.ins) begin
				if (ram_we) begin
					fill_q[sel_q] <= fill_q[sel_q] + FILL_W'(1);
				end
				k_q <= k_q + PCNT_W'(1);
			end

			if (cmd.load) begin
				out_idx_q   <= sel_q;
				out_place_q <= place_q;
				out_fill_q  <= (stat_q == STAT_OK) ? fill_q[sel_q] : '0;
				out_stat_q  <= stat_q;
				pcnt_q      <= '0;
				over_q      <= 1'b0;
			end
		end
	end

	assign cluster_index = out_idx_q;
	assign placement     = out_place_q;
	assign cluster_fill  = out_fill_q;
	assign status        = out_stat_q;

endmodule

### sv/bone_palette_cluster_assign_top.sv
// Bone palette cluster assignment. Each triangle sends its joint ids one per
// transfer; the block deduplicates them into a pending list of up to twelve
// joints and, on the transfer marked tlast, places the set into one of up to
// sixteen clusters (palettes of distinct joints) and returns one result: the
// cluster index, how it was placed (contained, overlap fit, free fit or new
// cluster), the cluster's fill after placement and a status (ok, table full
// or joint list overflowed). A transfer with the clear kind empties the table
// and gives no result; a joint transfer without tlast gives no result either.
// The joint store has a single read port and is swept one palette entry per
// cycle for every cluster, after which the new joints are written one per
// cycle. A finished result sits in an output register, so the next triangle
// may stream in while it waits to be taken. Nothing needs clearing after
// reset; the joint store only ever reads entries that have been written.
module bone_palette_cluster_assign_top import bpca_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [7:0] joint number, [11:8] skin_index, [15:12] zero
	input  logic [1:0]  s_tuser,  // [0] req_type, [1] joint_valid
	input  logic        s_tlast,
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [3:0] cluster_index, [5:4] placement,
	                              // [13:6] cluster_fill, [15:14] status
	// Register port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0]        slot_limit_q;
	logic              reg_hit;
	bpca_cmd_t         cmd;
	bpca_stat_t        stat;
	logic              item_places;
	logic [CL_W-1:0]   cluster_index;
	logic [1:0]        placement;
	logic [FILL_W-1:0] cluster_fill;
	logic [1:0]        status;

	// The register port never stalls. The only register is the palette limit.
	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == REG_SLOT_LIMIT);
	assign prdata  = reg_hit ? {24'd0, slot_limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_limit_q <= SLOT_LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			slot_limit_q <= pwdata[7:0];
		end
	end

	// A joint transfer carrying tlast is the one that triggers placement.
	assign item_places = (s_tuser[0] == REQ_JOINT) && s_tlast;

	bpca_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.item_places(item_places),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.stat       (stat),
		.cmd        (cmd)
	);

	bpca_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.req_type     (s_tuser[0]),
		.joint_valid  (s_tuser[1]),
		.jnt_id       (s_tdata[JOINT_ID_BITS-1:0]),
		.slot_limit   (slot_limit_q),
		.cluster_index(cluster_index),
		.placement    (placement),
		.cluster_fill (cluster_fill),
		.status       (status)
	);

	assign m_tdata = {status, cluster_fill, placement, cluster_index};

endmodule

### test/testbench.sv
module testbench;
	import bpca_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 10000000;
	// Worst settle time of one triangle: every cluster swept at its fullest, then the writes.
	localparam int SETTLE_CYCLES = 4 + MAX_CLUSTERS * (PALETTE_SLOTS + 3) + MAX_TRI_JOINTS + 100;
	localparam int HOLD_CYCLES = 3000;

	// One placement answer as the block reports it.
	typedef struct packed {
		logic [3:0] cl;
		logic [1:0] place;
		logic [7:0] fill;
		logic [1:0] status;
	} placement_t;

	// Scoreboard: keeps its own copy of the cluster table and predicts the answer for
	// every triangle that ends with an accepted transfer.
	class palette_scoreboard;
		logic [7:0] palette [MAX_CLUSTERS][PALETTE_SLOTS];
		int fill [MAX_CLUSTERS];
		int n_clusters;
		logic [7:0] pend [MAX_TRI_JOINTS];
		int n_pend;
		bit over;
		int limit;
		placement_t pending_answers [$];
		int errors;
		int answers;
		int by_place [4];
		int by_status [4];

		function void reset_state();
			foreach (fill[c]) fill[c] = 0;
			n_clusters = 0;
			n_pend = 0;
			over = 0;
			limit = SLOT_LIMIT_RESET;
		endfunction

		function int held(int c);
			int hits;
			hits = 0;
			for (int j = 0; j < fill[c]; j++)
				for (int k = 0; k < n_pend; k++)
					if (palette[c][j] == pend[k]) hits++;
			return hits;
		endfunction

		function void add_pending(int c);
			bit found;
			for (int k = 0; k < n_pend; k++) begin
				found = 0;
				for (int j = 0; j < fill[c]; j++)
					if (palette[c][j] == pend[k]) found = 1;
				if (!found && fill[c] < PALETTE_SLOTS) begin
					palette[c][fill[c]] = pend[k];
					fill[c]++;
				end
			end
		endfunction

		function void note_input(logic req, logic jv, logic [7:0] id, logic lst,
		                         logic [3:0] skin);
			placement_t a;
			bit seen, done;
			int lim, best, room, need;
			if (req == REQ_CLEAR) begin
				foreach (fill[c]) fill[c] = 0;
				n_clusters = 0;
				n_pend = 0;
				over = 0;
				return;
			end
			if (jv) begin
				seen = 0;
				for (int k = 0; k < n_pend; k++)
					if (pend[k] == id) seen = 1;
				if (!seen) begin
					if (n_pend < MAX_TRI_JOINTS) begin
						pend[n_pend] = id;
						n_pend++;
					end else begin
						over = 1;
					end
				end
			end
			if (!lst) return;
			a = '{cl: 0, place: PLACE_CONTAINED, fill: 0, status: STAT_OK};
			lim = (limit > PALETTE_SLOTS) ? PALETTE_SLOTS : limit;
			done = 0;
			if (over) begin
				a.status = STAT_OVER;
			end else begin
				for (int c = 0; c < n_clusters && !done; c++)
					if (held(c) == n_pend) begin
						a.cl = 4'(c);
						done = 1;
					end
				if (!done) begin
					best = lim;
					for (int c = 0; c < n_clusters; c++) begin
						room = lim - fill[c];
						need = n_pend - held(c);
						if (room > need && need < best) begin
							best = need;
							a.cl = 4'(c);
							done = 1;
						end
					end
					if (done) begin
						a.place = PLACE_OVERLAP;
						add_pending(a.cl);
					end
				end
				if (!done) begin
					best = lim;
					for (int c = 0; c < n_clusters; c++) begin
						room = lim - fill[c];
						if (room > n_pend && room < best) begin
							best = room;
							a.cl = 4'(c);
							done = 1;
						end
					end
					if (done) begin
						a.place = PLACE_FREE;
						add_pending(a.cl);
					end
				end
				if (!done) begin
					a.place = PLACE_NEW;
					if (n_clusters >= MAX_CLUSTERS) begin
						a.status = STAT_FULL;
					end else begin
						a.cl = 4'(n_clusters);
						fill[n_clusters] = 0;
						n_clusters++;
						add_pending(a.cl);
						done = 1;
					end
				end
				if (done) a.fill = 8'(fill[a.cl]);
			end
			n_pend = 0;
			over = 0;
			pending_answers.insert(pending_answers.size(), a);
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check(logic [15:0] d);
			placement_t got, exp;
			got = '{cl: d[3:0], place: d[5:4], fill: d[13:6], status: d[15:14]};
			if (pending_answers.size() == 0) begin
				report($sformatf("unexpected result %h", d));
				return;
			end
			exp = pending_answers.pop_front();
			answers++;
			by_place[exp.place]++;
			by_status[exp.status]++;
			if (got.cl !== exp.cl)
				report($sformatf("cluster_index %0d, want %0d", got.cl, exp.cl));
			if (got.place !== exp.place)
				report($sformatf("placement %0d, want %0d", got.place, exp.place));
			if (got.fill !== exp.fill)
				report($sformatf("cluster_fill %0d, want %0d", got.fill, exp.fill));
			if (got.status !== exp.status)
				report($sformatf("status %0d, want %0d", got.status, exp.status));
		endtask
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        s_tlast = 0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [15:0] m_tdata;
	logic        psel = 0;
	logic        penable = 0;
	logic        pwrite = 0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	palette_scoreboard board = new();
	int send_idle = 0;
	int take_idle = 0;
	bit hold_request = 0;
	int hold_left = 0;
	int cycles = 0;
	int items_sent = 0;
	logic [7:0] joint_pool [20];

	bone_palette_cluster_assign_top u_dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// Run limit; a hang anywhere ends here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// Result side. The ready is redrawn every cycle, except while a long hold-off is
	// running, which is counted here so that the block backs up into its input.
	always @(posedge clk) begin
		if (hold_request && hold_left == 0) begin
			hold_left <= HOLD_CYCLES;
			hold_request <= 0;
			m_tready <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= (hold_left == 1);
		end else begin
			m_tready <= ($urandom_range(99) >= take_idle);
		end
	end

	// Every accepted result transfer is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) board.check(m_tdata);
	end

	// One input transfer; the prediction is taken at the edge where it is accepted.
	// A random gap may follow, with tvalid low.
	task automatic send(logic req, logic jv, logic [7:0] id, logic lst, logic [3:0] skin);
		int gap;
		s_tvalid <= 1;
		s_tuser <= {jv, req};
		s_tdata <= {4'b0, skin, id};
		s_tlast <= lst;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_input(req, jv, id, lst, skin);
		items_sent++;
		gap = 0;
		while ($urandom_range(99) < send_idle) gap++;
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Register write followed by a read-back, both in setup and access cycles.
	task automatic write_limit(logic [7:0] value);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= 3'(4 * REG_SLOT_LIMIT);
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		board.limit = value;
		pwrite <= 0;
		penable <= 0;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		if (prdata[7:0] !== value)
			board.report($sformatf("slot_limit reads %0d, want %0d", prdata[7:0], value));
		psel <= 0;
		penable <= 0;
	endtask

	// Waits until every predicted result has been taken, then lets any unfinished
	// work drain before the register is touched.
	task automatic settle();
		s_tvalid <= 0;
		@(posedge clk);
		while (board.pending_answers.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic triangle(logic [7:0] ids [$], logic [3:0] skin);
		for (int i = 0; i < ids.size(); i++)
			send(REQ_JOINT, 1'b1, ids[i], i == ids.size() - 1, skin);
	endtask

	// One random triangle: mostly short joint lists drawn from a small pool so that
	// clusters get reused, with clears, empty lists and overflowing lists mixed in.
	task automatic random_triangle();
		int r, n;
		logic [7:0] base;
		logic [3:0] skin;
		r = $urandom_range(99);
		skin = 4'($urandom);
		if (r < 5) begin
			send(REQ_CLEAR, 1'($urandom), 8'($urandom), 1'($urandom), skin);
		end else if (r < 10) begin
			// More distinct joints than the pending list holds, with a repeat inside.
			base = 8'($urandom);
			n = $urandom_range(MAX_TRI_JOINTS + 1, MAX_TRI_JOINTS + 3);
			for (int i = 0; i < n; i++)
				send(REQ_JOINT, 1'b1, base + 8'(17 * i), 1'b0, skin);
			send(REQ_JOINT, 1'b1, base, 1'b1, skin);
		end else if (r < 15) begin
			n = $urandom_range(1, 2);
			for (int i = 0; i < n; i++) send(REQ_JOINT, 1'b0, 8'($urandom), i == n - 1, skin);
		end else begin
			n = $urandom_range(1, 5);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(9) == 0)
					send(REQ_JOINT, 1'b0, 8'($urandom), i == n - 1, skin);
				else if ($urandom_range(19) == 0)
					send(REQ_JOINT, 1'b1, 8'($urandom), i == n - 1, skin);
				else
					send(REQ_JOINT, 1'b1, joint_pool[$urandom_range(19)], i == n - 1, skin);
			end
		end
	endtask

	task automatic random_phase(logic [7:0] lim, int n_items, int s_idle, int t_idle,
	                            bit squeeze);
		int start;
		settle();
		write_limit(lim);
		send_idle = s_idle;
		take_idle = t_idle;
		foreach (joint_pool[i]) joint_pool[i] = 8'($urandom);
		if (squeeze) hold_request <= 1;
		start = items_sent;
		while (items_sent - start < n_items) random_triangle();
	endtask

	initial begin
		logic [7:0] ids [$];
		board.reset_state();
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed part at the reset value of the slot limit.
		send_idle = 0;
		take_idle = 0;
		send(REQ_JOINT, 1'b0, 8'hff, 1'b1, 4'h0);      // empty list opens an empty cluster
		send(REQ_JOINT, 1'b0, 8'h00, 1'b1, 4'hf);      // empty list is now contained
		ids = '{8'h00, 8'hff, 8'h00};
		triangle(ids, 4'hf);                           // duplicate joint, overlap fit
		ids = '{8'hff, 8'h00};
		triangle(ids, 4'h3);                           // contained
		ids = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		        8'h00, 8'h00, 8'h00, 8'h00};
		foreach (ids[i]) ids[i] = 8'(i * 19 + 1);
		triangle(ids, 4'ha);                           // list overflows
		send(REQ_CLEAR, 1'b0, 8'h00, 1'b0, 4'h0);      // clear
		ids = '{8'h5a, 8'ha5};
		triangle(ids, 4'h5);                           // new cluster after the clear

		random_phase(8'd78, 85, 23, 62, 0);
		random_phase(8'd1, 85, 23, 62, 0);             // clusters fill at once: table full
		random_phase(8'd255, 85, 62, 23, 0);           // above the palette size
		random_phase(8'd3, 85, 62, 23, 0);
		random_phase(8'd128, 85, 0, 0, 1);             // long output hold-off
		random_phase(8'($urandom_range(4, 127)), 85, 0, 0, 0);
		settle();

		$display("Sent %0d transfers; %0d triangle results: %0d contained, %0d overlap,",
		         items_sent, board.answers, board.by_place[0], board.by_place[1]);
		$display("%0d free fit, %0d new; %0d table full, %0d overflowed; %0d mismatches.",
		         board.by_place[2], board.by_place[3], board.by_status[1],
		         board.by_status[2], board.errors);
		if (board.errors == 0 && board.pending_answers.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
